// ===== design/amg_soc_pkg.sv =====
`default_nettype none
package amg_soc_pkg;

    // Row buffer geometry
    localparam int MAX_ROW_LEN = 64;
    localparam int ADDR_W      = $clog2(MAX_ROW_LEN);
    localparam int CNT_W       = $clog2(MAX_ROW_LEN + 1);

    localparam int THETA_W  = 17;
    localparam int VAL_W    = 32;
    localparam int PROD_W   = 48;
    localparam int OFFSET_W = 24;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

    typedef struct packed {
        logic [15:0]       row_index;
        logic [15:0]       col_index;
        logic signed [31:0] entry_value;
        logic              has_entry;
        logic              row_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0]         out_row;
        logic [15:0]         strong_col;
        logic                strong_valid;
        logic [6:0]          strong_count;
        logic [OFFSET_W-1:0] row_start;
        logic                run_last;
        logic                overflow;
    } out_item_t;

    // One buffered off-diagonal entry: column and negated value
    typedef struct packed {
        logic [15:0]             col;
        logic signed [VAL_W-1:0] val;
    } buf_entry_t;

endpackage
`default_nettype wire

// ===== design/amg_soc_ram.sv =====
`default_nettype none
module amg_soc_ram
    import amg_soc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire buf_entry_t        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output buf_entry_t             rdata
);

    buf_entry_t mem [MAX_ROW_LEN];
    buf_entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/amg_soc_strength.sv =====
`default_nettype none
module amg_soc_strength
    import amg_soc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    load,
    input  wire logic [THETA_W-1:0]      theta,
    input  wire logic signed [VAL_W-1:0] max_neg,
    input  wire logic signed [VAL_W-1:0] value,
    output logic                         meets_thr
);

    logic [PROD_W-1:0] thresh_reg;
    logic [PROD_W-1:0] thresh_next;
    logic [PROD_W-1:0] lhs;

    // theta * max, taken once per row; max is never negative
    assign thresh_next = PROD_W'({{(PROD_W-THETA_W){1'b0}}, theta}
                                 * {{(PROD_W-VAL_W+1){1'b0}}, max_neg[VAL_W-2:0]});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            thresh_reg <= thresh_next;
        end
    end

    // value * 65536 >= threshold; a negative value never passes
    assign lhs       = {1'b0, value[VAL_W-2:0], 16'h0000};
    assign meets_thr = !value[VAL_W-1] && (lhs >= thresh_reg);

endmodule
`default_nettype wire

// ===== design/amg_strength_of_connection.sv =====
`default_nettype none
// Channel   Dir  Handshake                 Payload
// item      in   item_valid / item_stall   in_item_t  (one matrix entry or marker)
// result    out  result_valid/result_stall out_item_t (one strong connection or a no-strong result)
// theta     cfg  theta_we                  theta_data (17-bit Q1.16)
//
// Entries load one per cycle while item_stall is low. After the row end item_stall stays high
// through a threshold step, a counting pass over the buffered entries, an emit pass that reads
// and checks each buffered entry (or one no-strong result when nothing is strong) and a closing
// step. result_stall extends the emit pass and the no-strong result; the row's last result may
// still wait while the next row loads.
// Reset clears counters, maximum and offset and sets theta to 0.25; the buffer is not cleared.
module amg_strength_of_connection
    import amg_soc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire in_item_t           item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output out_item_t               result,
    input  wire logic               theta_we,
    input  wire logic [THETA_W-1:0] theta_data
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_THR   = 3'd1;
    localparam logic [2:0] ST_CNT   = 3'd2;
    localparam logic [2:0] ST_EMRD  = 3'd3;
    localparam logic [2:0] ST_EMCHK = 3'd4;
    localparam logic [2:0] ST_NONE  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [THETA_W-1:0]      theta_reg;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic signed [VAL_W-1:0] max_reg, max_next;
    logic                    ovf_reg, ovf_next;
    logic [OFFSET_W-1:0]     offset_reg, offset_next;
    logic [15:0]             row_reg, row_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        emit_reg, emit_next;
    logic                    pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg, out_next;

    logic                    accept;
    logic                    off_diag;
    logic signed [VAL_W-1:0] neg_val;
    logic                    wr_en;
    buf_entry_t              wr_data;
    logic                    rd_en;
    buf_entry_t              rd_data;
    logic                    meets_thr;
    logic                    out_free;
    logic [OFFSET_W:0]       offset_sum;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_LOAD);
    assign off_diag   = item.has_entry && (item.col_index != item.row_index);
    assign out_free   = !out_valid_reg || !result_stall;

    // Saturating negation of the Q16.16 value
    assign neg_val = (item.entry_value == {1'b1, {(VAL_W-1){1'b0}}})
                   ? {1'b0, {(VAL_W-1){1'b1}}} : -item.entry_value;

    assign wr_en   = accept && off_diag && (fill_reg < CNT_W'(MAX_ROW_LEN));
    assign wr_data = '{col: item.col_index, val: neg_val};
    assign rd_en   = ((state_reg == ST_CNT) && (idx_reg < fill_reg))
                  || ((state_reg == ST_EMRD) && (idx_reg < fill_reg));

    assign offset_sum = {1'b0, offset_reg} + {{(OFFSET_W+1-CNT_W){1'b0}}, count_reg};

    amg_soc_ram u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    amg_soc_strength u_strength (
        .clk       (clk),
        .load      (state_reg == ST_THR),
        .theta     (theta_reg),
        .max_neg   (max_reg),
        .value     (rd_data.val),
        .meets_thr (meets_thr)
    );

    // Sequencer: load, threshold, count pass, emit pass or no-strong result, closing step
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        max_next       = max_reg;
        ovf_next       = ovf_reg;
        offset_next    = offset_reg;
        row_next       = row_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        emit_next      = emit_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (off_diag)
                    begin
                        if (wr_en)
                        begin
                            fill_next = fill_reg + 1'b1;
                            if (neg_val > max_reg)
                            begin
                                max_next = neg_val;
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (item.row_end)
                    begin
                        row_next   = item.row_index;
                        state_next = ST_THR;
                    end
                end
            end
            ST_THR:
            begin
                idx_next   = '0;
                count_next = '0;
                state_next = ST_CNT;
            end
            ST_CNT:
            begin
                if (rd_en)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg && meets_thr)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (!rd_en && !pend_reg)
                begin
                    idx_next   = '0;
                    emit_next  = '0;
                    state_next = (count_reg == '0) ? ST_NONE : ST_EMRD;
                end
            end
            ST_EMRD:
            begin
                if (rd_en)
                begin
                    state_next = ST_EMCHK;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_EMCHK:
            begin
                if (!meets_thr)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_EMRD;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{out_row: row_reg, strong_col: rd_data.col,
                                 strong_valid: 1'b1, strong_count: count_reg,
                                 row_start: offset_reg,
                                 run_last: (emit_reg + 1'b1 == count_reg),
                                 overflow: ovf_reg};
                    emit_next  = emit_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_EMRD;
                end
            end
            ST_NONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{out_row: row_reg, strong_col: 16'h0000,
                                 strong_valid: 1'b0, strong_count: '0,
                                 row_start: offset_reg, run_last: 1'b1,
                                 overflow: ovf_reg};
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                offset_next = offset_sum[OFFSET_W] ? OFFSET_MAX : offset_sum[OFFSET_W-1:0];
                fill_next   = '0;
                max_next    = '0;
                ovf_next    = 1'b0;
                state_next  = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            theta_reg     <= THETA_W'(16384);
            fill_reg      <= '0;
            max_reg       <= '0;
            ovf_reg       <= 1'b0;
            offset_reg    <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            emit_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (theta_we)
            begin
                theta_reg <= theta_data;
            end
            fill_reg      <= fill_next;
            max_reg       <= max_next;
            ovf_reg       <= ovf_next;
            offset_reg    <= offset_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            emit_reg      <= emit_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
    import amg_soc_pkg::*;

    localparam int DIR_N = 20;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_mode_e;

    // One directed stimulus row; want is used only where typed is set
    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    in_item_t           item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    out_item_t          result;
    logic               theta_we     = 1'b0;
    logic [THETA_W-1:0] theta_data   = '0;

    amg_strength_of_connection dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .theta_we     (theta_we),
        .theta_data   (theta_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Predictor state: buffered row, its maximum, drop flag, running offset, theta
    logic [15:0]             buf_cols [MAX_ROW_LEN];
    logic signed [VAL_W-1:0] buf_negs [MAX_ROW_LEN];
    int                      buf_fill      = 0;
    logic signed [VAL_W-1:0] row_max_neg   = '0;
    bit                      row_dropped   = 1'b0;
    logic [OFFSET_W-1:0]     strong_offset = '0;
    logic [THETA_W-1:0]      theta_q16     = 17'd16384;

    // Strong connections still owed by the block, oldest first
    out_item_t strong_q [$];

    int n_errors    = 0;
    int n_items     = 0;
    int n_rows      = 0;
    int n_predicted = 0;
    int n_results   = 0;
    int n_settings  = 0;
    int burst_left  = 0;

    stall_mode_e stall_mode = STALL_NONE;
    int          stall_left = 0;

    function automatic logic signed [VAL_W-1:0] negated_q16(logic signed [VAL_W-1:0] v);
        // -2^31 has no positive counterpart; clamp to the largest value
        if (v == {1'b1, {(VAL_W-1){1'b0}}})
            return {1'b0, {(VAL_W-1){1'b1}}};
        return -v;
    endfunction

    // Exact test neg >= theta * max, scaled to avoid rounding
    function automatic bit meets_threshold(logic signed [VAL_W-1:0] neg);
        longint lhs;
        longint rhs;
        lhs = longint'(neg) * 64'sd65536;
        rhs = longint'(theta_q16) * longint'(row_max_neg);
        return lhs >= rhs;
    endfunction

    // Strong connections, or the no-strong result, caused by one accepted entry transfer
    function automatic void row_strength_predict(input in_item_t it, ref out_item_t res [$]);
        logic signed [VAL_W-1:0] neg;
        int                      count;
        int                      n;
        int                      sum;
        out_item_t               o;
        res.delete();
        if (it.has_entry && it.col_index != it.row_index)
        begin
            neg = negated_q16(it.entry_value);
            if (buf_fill < MAX_ROW_LEN)
            begin
                buf_cols[buf_fill] = it.col_index;
                buf_negs[buf_fill] = neg;
                buf_fill++;
                if (neg > row_max_neg)
                    row_max_neg = neg;
            end
            else
                row_dropped = 1'b1;
        end
        if (!it.row_end)
            return;

        count = 0;
        for (int i = 0; i < buf_fill; i++)
            if (meets_threshold(buf_negs[i]))
                count++;

        o           = '0;
        o.out_row   = it.row_index;
        o.row_start = strong_offset;
        o.overflow  = row_dropped;
        if (count == 0)
        begin
            o.run_last = 1'b1;
            res = {res, o};
        end
        else
        begin
            n              = 0;
            o.strong_valid = 1'b1;
            o.strong_count = count[6:0];
            for (int i = 0; i < buf_fill; i++)
            begin
                if (meets_threshold(buf_negs[i]))
                begin
                    n++;
                    o.strong_col = buf_cols[i];
                    o.run_last   = (n == count);
                    res = {res, o};
                end
            end
        end

        // Offset saturates; row state clears for the next row
        sum           = int'(strong_offset) + count;
        strong_offset = (sum > int'(OFFSET_MAX)) ? OFFSET_MAX : sum[OFFSET_W-1:0];
        buf_fill      = 0;
        row_max_neg   = '0;
        row_dropped   = 1'b0;
    endfunction

    // Drive one entry in bursts with random gaps; called at a falling edge
    task automatic send_entry(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t got [$];
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        row_strength_predict(it, got);
        if (typed)
            strong_q = {strong_q, want};
        else
            strong_q = {strong_q, got};
        n_predicted += typed ? 1 : got.size();
        n_items++;
        if (it.row_end)
            n_rows++;
        @(negedge clk);
    endtask

    // Theta changes only once the block has drained and is back to loading
    task automatic write_theta(input logic [THETA_W-1:0] v);
        item_valid <= 1'b0;
        while (strong_q.size() != 0 || item_stall)
            @(negedge clk);
        repeat (8) @(negedge clk);
        theta_we   <= 1'b1;
        theta_data <= v;
        @(negedge clk);
        theta_we   <= 1'b0;
        theta_q16  = v;
        n_settings++;
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return -$urandom_range(1, 32'h0004_0000);
            4:          return $urandom_range(0, 32'h0004_0000);
            5, 6:       return $urandom;
            7:          return -$urandom_range(32'h0001_0000, 32'h0003_0000);
            8:          return 32'h0000_0000;
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // One row of random content; a long row runs past the buffer
    task automatic send_random_row(input bit long_row);
        logic [15:0] r;
        int          len;
        bit          empty;
        bit          noisy;
        in_item_t    it;
        noisy = !long_row;
        empty = noisy && ($urandom_range(0, 11) == 0);
        if (long_row)
            r = 16'($urandom_range(8, 65535));
        else
            r = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        if (long_row)
            len = $urandom_range(66, 68);
        else if (empty)
            len = 1;
        else
            len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
        begin
            it.row_index = r;
            if (noisy && $urandom_range(0, 15) == 0)
                it.row_index = 16'($urandom_range(0, 7));
            it.col_index = (r < 8) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            if (noisy && $urandom_range(0, 7) == 0)
                it.col_index = it.row_index;
            it.entry_value = rand_value();
            it.has_entry   = !empty && (!noisy || $urandom_range(0, 15) != 0);
            it.row_end     = (i == len - 1);
            send_entry(it, 1'b0, '0);
        end
    endtask

    // Receiver back-pressure: randomly chosen free, light and heavy stretches
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 2));
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE: result_stall <= 1'b0;
            STALL_HALF: result_stall <= ($urandom_range(0, 1) == 1);
            default:    result_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            n_results++;
            if (strong_q.size() == 0)
            begin
                $error("result transfer with nothing expected: row 0x%0h col 0x%0h",
                       result.out_row, result.strong_col);
                n_errors++;
            end
            else
            begin
                want = strong_q.pop_front();
                check_field("out_row", want.out_row, result.out_row);
                check_field("strong_col", want.strong_col, result.strong_col);
                check_field("strong_valid", want.strong_valid, result.strong_valid);
                check_field("strong_count", want.strong_count, result.strong_count);
                check_field("row_start", want.row_start, result.row_start);
                check_field("run_last", want.run_last, result.run_last);
                check_field("overflow", want.overflow, result.overflow);
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        dir_row_t           dir_tab [DIR_N];
        logic [THETA_W-1:0] phase_theta [5];
        int                 start_items;

        dir_tab = '{
            // empty row right after reset
            '{'{16'd5, 16'd0, 32'h0000_0000, 1'b0, 1'b1}, 1'b1,
              '{16'd5, 16'd0, 1'b0, 7'd0, 24'd0, 1'b1, 1'b0}},
            // diagonal, saturating negation, most positive value, marker mid-row
            '{'{16'd1, 16'd1, 32'h0004_0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd1, 16'd0, 32'hFFFF_0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd1, 16'd2, 32'h8000_0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd1, 16'd65535, 32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd1, 16'd3, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, '0},
            '{'{16'd1, 16'd4, 32'hE000_0000, 1'b1, 1'b1}, 1'b0, '0},
            // only positive off-diagonals: nothing strong
            '{'{16'd65535, 16'd0, 32'h0001_0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd65535, 16'd65534, 32'h7FFF_FFFF, 1'b1, 1'b1}, 1'b0, '0},
            // zero and tiny values, row closed by a diagonal entry
            '{'{16'd7, 16'd8, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd7, 16'd9, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd7, 16'd7, 32'h8000_0000, 1'b1, 1'b1}, 1'b0, '0},
            // row index changes within the row
            '{'{16'd10, 16'd11, 32'hFFF0_0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd11, 16'd11, 32'hFFFF_0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd12, 16'd11, 32'hFFFE_0000, 1'b1, 1'b1}, 1'b0, '0},
            // diagonal-only row
            '{'{16'd3, 16'd3, 32'hFFFF_0000, 1'b1, 1'b1}, 1'b0, '0},
            // marker with alternating bit patterns
            '{'{16'h5555, 16'hAAAA, 32'h5555_AAAA, 1'b0, 1'b1}, 1'b0, '0},
            // entry exactly at the threshold
            '{'{16'd20, 16'd21, 32'hFFFF_0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd20, 16'd22, 32'hFFFF_0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'd20, 16'd23, 32'hFFFF_C000, 1'b1, 1'b1}, 1'b0, '0}
        };
        phase_theta = '{17'd0, 17'd65536, 17'd131071,
                        17'($urandom_range(1, 65535)), 17'd16384};

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            send_entry(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

        // Random rows under each theta setting; theta zero gets a buffer overrun
        for (int p = 0; p < 5; p++)
        begin
            write_theta(phase_theta[p]);
            start_items = n_items;
            if (p == 0)
                send_random_row(1'b1);
            while (n_items - start_items < 4 || (p == 0 && n_items - start_items < 70))
                send_random_row(1'b0);
        end
        item_valid <= 1'b0;

        // Drain, then give the block time to show any stray transfer
        for (int w = 0; w < 200000 && strong_q.size() != 0; w++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (strong_q.size() != 0)
        begin
            $error("%0d expected result transfers never arrived", strong_q.size());
            n_errors++;
        end

        $display("Covered %0d entry transfers in %0d rows under %0d theta writes plus reset value,",
                 n_items, n_rows, n_settings);
        $display("including a buffer overrun row; %0d of %0d predicted result transfers compared.",
                 n_results, n_predicted);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
